[src/gtg_pkg.sv]
// Shared types, constants and the CORDIC arctangent table of the steering controller.
`default_nettype none
package gtg_pkg;
  localparam logic [1:0] FUNC_POSE   = 2'd0;
  localparam logic [1:0] FUNC_TARGET = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  localparam logic [2:0] REG_LIN_GAIN  = 3'd0;
  localparam logic [2:0] REG_ANG_GAIN  = 3'd1;
  localparam logic [2:0] REG_REACH     = 3'd2;
  localparam logic [2:0] REG_TGT_MIN   = 3'd3;
  localparam logic [2:0] REG_TGT_MAX   = 3'd4;

  localparam int GUARD = 8;
  // CORDIC datapath: 17-bit vector plus guard bits plus growth headroom.
  localparam int CW = 28;
  localparam int ZW = 24;
  localparam logic signed [ZW-1:0] PI_Z = 24'sd3294199;
  localparam logic signed [16:0] PI_Q12 = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
  localparam logic [15:0] KGAIN_Q16 = 16'd39797;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 24'sd823550;  5'd1: r = 24'sd486170;  5'd2: r = 24'sd256879;
      5'd3: r = 24'sd130396;  5'd4: r = 24'sd65451;   5'd5: r = 24'sd32757;
      5'd6: r = 24'sd16383;   5'd7: r = 24'sd8192;    5'd8: r = 24'sd4096;
      5'd9: r = 24'sd2048;    5'd10: r = 24'sd1024;   5'd11: r = 24'sd512;
      5'd12: r = 24'sd256;    5'd13: r = 24'sd128;    5'd14: r = 24'sd64;
      5'd15: r = 24'sd32;     5'd16: r = 24'sd16;     5'd17: r = 24'sd8;
      5'd18: r = 24'sd4;      5'd19: r = 24'sd2;      5'd20: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic start;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic [CW-1:0] mag;
    logic signed [ZW-1:0] ang;
  } cordic_rsp_t;
endpackage
`default_nettype wire

[src/gtg_cordic.sv]
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
`default_nettype none
module gtg_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire gtg_pkg::cordic_req_t req,
  output gtg_pkg::cordic_rsp_t rsp
);
  localparam int SW = $clog2(CORDIC_STEPS + 1);
  logic signed [gtg_pkg::CW-1:0] x, y;
  logic signed [gtg_pkg::ZW-1:0] z;
  logic [SW-1:0] step;
  logic busy;
  logic done;
  logic signed [gtg_pkg::CW-1:0] xs, ys;
  logic [4:0] idx;

  assign idx = 5'(step);
  assign xs = x >>> step;
  assign ys = y >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        if (req.dx < 0) begin
          x <= gtg_pkg::CW'(-(18'(req.dx))) <<< gtg_pkg::GUARD;
          y <= gtg_pkg::CW'(-(18'(req.dy))) <<< gtg_pkg::GUARD;
          z <= (req.dy >= 0) ? gtg_pkg::PI_Z : -gtg_pkg::PI_Z;
        end else begin
          x <= gtg_pkg::CW'(req.dx) <<< gtg_pkg::GUARD;
          y <= gtg_pkg::CW'(req.dy) <<< gtg_pkg::GUARD;
          z <= '0;
        end
      end else if (busy) begin
        if (step == SW'(CORDIC_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
          if (y >= 0) begin
            x <= x + ys; y <= y - xs; z <= z + gtg_pkg::atan_entry(idx);
          end else begin
            x <= x - ys; y <= y + xs; z <= z - gtg_pkg::atan_entry(idx);
          end
        end
      end
    end
  end
  assign rsp = {done, x, z};
endmodule
`default_nettype wire

[src/gtg_post.sv]
// Post-processing: distance scaling, reach test, heading error wrap and gains.
`default_nettype none
module gtg_post (
  input  wire logic clk,
  input  wire logic rst,
  input  wire gtg_pkg::cordic_rsp_t rsp,
  input  wire logic signed [14:0] pose_heading,
  input  wire logic [7:0] lin_gain,
  input  wire logic [7:0] ang_gain,
  input  wire logic [14:0] reach,
  output logic done,
  output logic [16:0] lin_out,
  output logic signed [17:0] ang_out,
  output logic reach_out
);
  // Registered in order: distance product and bearing; reach test, error wrap and
  // linear gain product; angular gain product; rounding and saturation.
  logic v1, v2, v3;
  logic [43:0] dprod;
  logic signed [16:0] bearing;
  logic [19:0] range_q;
  logic signed [17:0] err;
  logic signed [17:0] err_raw;
  logic [27:0] lprod;
  logic signed [27:0] aprod;
  logic near;
  logic [23:0] lr;
  logic signed [27:0] ar;

  assign range_q = 20'((dprod[43:16] + 28'd128) >> gtg_pkg::GUARD);
  assign err_raw = 18'(bearing) - 18'(pose_heading);
  assign lr = 24'((lprod + 28'd8) >> 4);
  assign ar = (aprod + 28'sd8) >>> 4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      v1 <= rsp.done; v2 <= v1; v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done) begin
      dprod <= 44'(rsp.mag) * 44'(gtg_pkg::KGAIN_Q16);
      bearing <= 17'((rsp.ang + 24'sd128) >>> 8);
    end
    if (v1) begin
      near <= range_q <= 20'(reach);
      if (err_raw > 18'(gtg_pkg::PI_Q12)) err <= err_raw - 18'(gtg_pkg::TWO_PI_Q12);
      else if (err_raw < -18'(gtg_pkg::PI_Q12)) err <= err_raw + 18'(gtg_pkg::TWO_PI_Q12);
      else err <= err_raw;
      lprod <= 28'(range_q) * 28'(lin_gain);
    end
    if (v2) begin
      aprod <= 28'(err) * $signed({20'd0, ang_gain});
      reach_out <= near;
    end
    if (v3) begin
      if (reach_out) begin
        lin_out <= '0;
        ang_out <= '0;
      end else begin
        lin_out <= (lr > 24'd131071) ? 17'd131071 : lr[16:0];
        if (ar > 28'sd131071) ang_out <= 18'sd131071;
        else if (ar < -28'sd131072) ang_out <= -18'sd131072;
        else ang_out <= ar[17:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v3;
  end
endmodule
`default_nettype wire

[src/go_to_goal_steering_controller_core.sv]
// Top level of the go-to-goal steering controller.
// Pose and target items are taken one per cycle while in_stall is low; a tick with pose
// and target known starts the CORDIC; its result then passes the post stages to the output.
// After such a tick the input stalls until its result has been taken at the output.
// Synchronous active-high reset clears the pose and target flags and loads register defaults.
`default_nettype none
module go_to_goal_steering_controller_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] func,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [14:0] heading,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [16:0] linear_speed,
  output logic signed [17:0] angular_speed,
  output logic reached,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [7:0] lin_gain, ang_gain;
  logic [14:0] reach;
  logic signed [15:0] tmin, tmax;
  logic signed [15:0] px, py, gx, gy;
  logic signed [14:0] ph;
  logic pknown, gknown, busy;
  gtg_pkg::cordic_req_t req;
  gtg_pkg::cordic_rsp_t rsp;
  logic pdone;
  logic [16:0] plin;
  logic signed [17:0] pang;
  logic preach;
  logic acc;
  // Tracks a tick inside the CORDIC and post stages.
  logic rsp_pending;

  // A new item waits until the previous result has left the output register.
  assign in_stall = busy;
  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_gain <= 8'd32; ang_gain <= 8'd96; reach <= 15'd1024;
      tmin <= '0; tmax <= 16'sd22528;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtg_pkg::REG_LIN_GAIN: lin_gain <= cfg_data[7:0];
        gtg_pkg::REG_ANG_GAIN: ang_gain <= cfg_data[7:0];
        gtg_pkg::REG_REACH:    reach <= cfg_data[14:0];
        gtg_pkg::REG_TGT_MIN:  tmin <= cfg_data;
        gtg_pkg::REG_TGT_MAX:  tmax <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0; py <= '0; ph <= '0; gx <= '0; gy <= '0;
      pknown <= 1'b0; gknown <= 1'b0; busy <= 1'b0; req.start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      req.start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (pdone) begin
        out_valid <= 1'b1;
        linear_speed <= plin; angular_speed <= pang; reached <= preach;
      end
      if (busy && !pdone && !out_valid && !req.start && !rsp_pending) busy <= 1'b0;
      if (acc) begin
        unique case (func)
          gtg_pkg::FUNC_POSE: begin
            px <= pos_x; py <= pos_y; ph <= heading; pknown <= 1'b1;
          end
          gtg_pkg::FUNC_TARGET: begin
            if (pos_x > tmin && pos_x < tmax && pos_y > tmin && pos_y < tmax) begin
              gx <= pos_x; gy <= pos_y; gknown <= 1'b1;
            end
          end
          gtg_pkg::FUNC_TICK: begin
            if (pknown && gknown) begin
              busy <= 1'b1;
              req.start <= 1'b1;
              req.dx <= 17'(gx) - 17'(px);
              req.dy <= 17'(gy) - 17'(py);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_pending <= 1'b0;
    else if (req.start) rsp_pending <= 1'b1;
    else if (pdone) rsp_pending <= 1'b0;
  end

  gtg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  gtg_post u_post (
    .clk(clk), .rst(rst), .rsp(rsp), .pose_heading(ph),
    .lin_gain(lin_gain), .ang_gain(ang_gain), .reach(reach),
    .done(pdone), .lin_out(plin), .ang_out(pang), .reach_out(preach)
  );
endmodule
`default_nettype wire

[src/gtg_checker.sv]
// Port-level checker for the steering controller, bound to the top level.
`default_nettype none
module gtg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [16:0] linear_speed,
  input wire logic signed [17:0] angular_speed,
  input wire logic reached
);
  a_reach_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && reached |-> linear_speed == '0 && angular_speed == '0)
    else $error("reached result with nonzero speed");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(linear_speed) && $stable(reached))
    else $error("stalled result changed");
  a_no_take_while_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule
bind go_to_goal_steering_controller_core gtg_checker u_gtg_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .linear_speed(linear_speed),
  .angular_speed(angular_speed), .reached(reached)
);
`default_nettype wire
